// File: hdl/sha256_message_hash_top_assert.svh
// assertion macros shared by the sha-256 message hash rtl
`ifndef SHA256_MESSAGE_HASH_TOP_ASSERT_SVH
`define SHA256_MESSAGE_HASH_TOP_ASSERT_SVH

// same-cycle implication, checked on every clock edge out of reset
`define SMH_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every clock edge out of reset
`define SMH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/smh_pkg.sv
// types, constants and round functions of the sha-256 message hash
`timescale 1ns / 1ps

package smh_pkg;

    localparam int BLOCK_WORDS = 16;

    // one input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } msg_beat_t;

    // one output beat
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        last_word;
    } dig_beat_t;

    typedef logic [7:0][31:0] work_vars_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        logic [63:0] d;
        begin
            d = {x, x} >> n;
            return d[31:0];
        end
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    // initial hash words
    function automatic logic [31:0] init_hash(input logic [2:0] i);
        logic [31:0] r;
        begin
            unique case (i)
                3'd0: r = 32'h6a09e667;
                3'd1: r = 32'hbb67ae85;
                3'd2: r = 32'h3c6ef372;
                3'd3: r = 32'ha54ff53a;
                3'd4: r = 32'h510e527f;
                3'd5: r = 32'h9b05688c;
                3'd6: r = 32'h1f83d9ab;
                3'd7: r = 32'h5be0cd19;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction

    // round constants
    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] r;
        begin
            unique case (t)
                6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
                6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
                6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
                6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
                6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
                6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
                6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
                6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
                6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
                6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
                6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
                6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
                6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
                6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
                6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
                6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
                6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
                6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
                6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
                6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
                6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
                6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
                6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
                6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
                6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
                6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
                6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
                6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
                6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
                6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
                6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
                6'd62: r = 32'hbef9a3f7; 6'd63: r = 32'hc67178f2;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction

endpackage

// File: hdl/smh_ram.sv
// generic single-write single-read ram with registered read data
`timescale 1ns / 1ps

module smh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/smh_round.sv
// one compression round and one message schedule expansion step
`timescale 1ns / 1ps

module smh_round (
    input  smh_pkg::work_vars_t v,
    input  logic [31:0]         wt,
    input  logic [31:0]         k,
    input  logic [31:0]         x16,
    input  logic [31:0]         x15,
    input  logic [31:0]         x7,
    input  logic [31:0]         x2,
    output smh_pkg::work_vars_t v_next,
    output logic [31:0]         w_new
);

    logic [31:0] t1;
    logic [31:0] t2;

    // round temporaries
    assign t1 = v[7] + smh_pkg::big_sigma1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k + wt;
    assign t2 = smh_pkg::big_sigma0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

    // rotate the working variables
    always_comb
    begin
        v_next[7] = v[6];
        v_next[6] = v[5];
        v_next[5] = v[4];
        v_next[4] = v[3] + t1;
        v_next[3] = v[2];
        v_next[2] = v[1];
        v_next[1] = v[0];
        v_next[0] = t1 + t2;
    end

    // schedule word for rounds 16 and up
    assign w_new = x16 + smh_pkg::small_sigma0(x15) + x7 + smh_pkg::small_sigma1(x2);

endmodule

// File: hdl/sha256_message_hash_top.sv
// sha-256 message hash: byte packing, padding, round sequencer and digest output
//
// Usage:
// - msg channel: one beat carries an optional message byte and an optional
//   end mark. msg_stall is high while a block is compressed, padded or the
//   digest is being sent; a byte beat without an end mark that does not fill a block leaves it low.
// - dig channel: after an end mark the eight digest words leave in order,
//   word_number 0 first, last_word set on word 7. S_OUT_RD reads each word
//   and S_OUT_LD loads it into the output register, waiting while dig_stall holds.
// - A full block runs S_LOADV to load the working variables, then per round
//   S_RD1 and S_RD2, plus S_WN for rounds 16..63 (the schedule memory is
//   read twice per expanded word), and S_RND; S_FINC then folds the result back
//   into the chain memory. Padding writes up to 16 schedule words, 1 a cycle.
// - An end mark therefore costs one or two blocks plus the digest readout
//   before the next beat is taken.
// - Reset clears the control state and marks all chain words as holding the
//   initial hash; no clearing pass runs, the first beat is taken at once.
// - A stalled digest beat stays in the output register unchanged; the
//   readout waits for it.
`timescale 1ns / 1ps

`include "sha256_message_hash_top_assert.svh"

module sha256_message_hash_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                msg_valid,
    output logic                msg_stall,
    input  smh_pkg::msg_beat_t  msg,
    output logic                dig_valid,
    input  logic                dig_stall,
    output smh_pkg::dig_beat_t  dig
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PAD    = 4'd1;
    localparam logic [3:0] S_LOADV  = 4'd2;
    localparam logic [3:0] S_RD1    = 4'd3;
    localparam logic [3:0] S_RD2    = 4'd4;
    localparam logic [3:0] S_WN     = 4'd5;
    localparam logic [3:0] S_RND    = 4'd6;
    localparam logic [3:0] S_FINC   = 4'd7;
    localparam logic [3:0] S_OUT_RD = 4'd8;
    localparam logic [3:0] S_OUT_LD = 4'd9;

    localparam logic [1:0] JOB_DATA  = 2'd0;
    localparam logic [1:0] JOB_SPILL = 2'd1;
    localparam logic [1:0] JOB_FINAL = 2'd2;

    localparam int SAW = $clog2(smh_pkg::BLOCK_WORDS);

    logic [3:0]          state_reg, state_next;
    logic [31:0]         cnt_reg, cnt_next;
    logic [31:0]         acc_reg, acc_next;
    logic                end_pend_reg, end_pend_next;
    logic                pad2_reg, pad2_next;
    logic [SAW-1:0]      pad_idx_reg, pad_idx_next;
    logic [1:0]          job_reg, job_next;
    logic [3:0]          seq_reg, seq_next;
    logic [5:0]          t_reg, t_next;
    logic [31:0]         x16_reg, x16_next;
    logic [31:0]         x15_reg, x15_next;
    logic [31:0]         wt_reg, wt_next;
    smh_pkg::work_vars_t v_reg, v_next;
    logic [7:0]          vld_reg, vld_next;
    logic [2:0]          oj_reg, oj_next;
    logic                dig_valid_reg;
    smh_pkg::dig_beat_t  dig_reg;

    logic                accept;
    logic                dig_load;
    logic [5:0]          pos;
    logic [31:0]         cnt_inc;
    logic [4:0]          shift;
    logic [31:0]         new_acc;
    logic [4:0]          psh;
    logic [31:0]         marker;
    logic [31:0]         len_word;
    logic [31:0]         pad_word;
    logic [2:0]          seqm1;
    logic [2:0]          cidx;
    logic [31:0]         chv;
    logic [31:0]         w_new;
    smh_pkg::work_vars_t v_rnd;

    logic                s_we;
    logic [SAW-1:0]      s_waddr;
    logic [31:0]         s_wdata;
    logic [SAW-1:0]      s_ra_a, s_ra_b;
    logic [31:0]         rd_a, rd_b;
    logic                c_we;
    logic [2:0]          c_waddr, c_raddr;
    logic [31:0]         c_wdata, c_rdata;

    // schedule window, two copies for two reads a cycle
    smh_ram #(.WIDTH(32), .DEPTH(smh_pkg::BLOCK_WORDS)) u_sched_a (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_ra_a), .rdata(rd_a)
    );

    smh_ram #(.WIDTH(32), .DEPTH(smh_pkg::BLOCK_WORDS)) u_sched_b (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_ra_b), .rdata(rd_b)
    );

    // chain value memory
    smh_ram #(.WIDTH(32), .DEPTH(8)) u_chain (
        .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
        .raddr(c_raddr), .rdata(c_rdata)
    );

    // round and schedule arithmetic
    smh_round u_round (
        .v(v_reg), .wt(wt_reg), .k(smh_pkg::round_k(t_reg)),
        .x16(x16_reg), .x15(x15_reg), .x7(rd_a), .x2(rd_b),
        .v_next(v_rnd), .w_new(w_new)
    );

    assign msg_stall = (state_reg != S_IDLE);
    assign accept    = msg_valid && !msg_stall;
    assign dig_valid = dig_valid_reg;
    assign dig       = dig_reg;

    // byte packing into the partial word
    assign pos     = cnt_reg[5:0];
    assign cnt_inc = cnt_reg + 32'd1;
    assign shift   = {~pos[1:0], 3'b000};
    assign new_acc = (pos[1:0] == 2'd0) ? {msg.data_byte, 24'h0}
                                        : (acc_reg | ({24'h0, msg.data_byte} << shift));

    // padding words
    assign psh      = {~pos[1:0], 3'b000};
    assign marker   = (pos[1:0] == 2'd0) ? 32'h8000_0000
                    : ((acc_reg & (32'hFFFF_FFFF << (psh + 5'd8))) | (32'h80 << psh));
    assign len_word = {cnt_reg[28:0], 3'b000};

    always_comb
    begin
        if (!pad2_reg && pad_idx_reg == pos[5:2])
        begin
            pad_word = marker;
        end
        else if (pad_idx_reg == 4'd15 && (pad2_reg || pos < 6'd56))
        begin
            pad_word = len_word;
        end
        else
        begin
            pad_word = 32'h0;
        end
    end

    // chain word with reset value for words not yet written
    assign seqm1 = seq_reg[2:0] - 3'd1;
    assign cidx  = (state_reg == S_OUT_LD) ? oj_reg : seqm1;
    assign chv   = vld_reg[cidx] ? c_rdata : smh_pkg::init_hash(cidx);

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        acc_next      = acc_reg;
        end_pend_next = end_pend_reg;
        pad2_next     = pad2_reg;
        pad_idx_next  = pad_idx_reg;
        job_next      = job_reg;
        seq_next      = seq_reg;
        t_next        = t_reg;
        x16_next      = x16_reg;
        x15_next      = x15_reg;
        wt_next       = wt_reg;
        v_next        = v_reg;
        vld_next      = vld_reg;
        oj_next       = oj_reg;
        dig_load      = 1'b0;
        s_we          = 1'b0;
        s_waddr       = '0;
        s_wdata       = 32'h0;
        s_ra_a        = '0;
        s_ra_b        = '0;
        c_we          = 1'b0;
        c_waddr       = 3'd0;
        c_wdata       = 32'h0;
        c_raddr       = 3'd0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (msg.byte_present)
                    begin
                        acc_next = new_acc;
                        cnt_next = cnt_inc;
                        if (pos[1:0] == 2'd3)
                        begin
                            s_we    = 1'b1;
                            s_waddr = pos[5:2];
                            s_wdata = new_acc;
                        end
                        if (pos == 6'd63)
                        begin
                            state_next    = S_LOADV;
                            seq_next      = 4'd0;
                            job_next      = JOB_DATA;
                            end_pend_next = msg.end_of_message;
                        end
                        else if (msg.end_of_message)
                        begin
                            state_next   = S_PAD;
                            pad2_next    = 1'b0;
                            pad_idx_next = cnt_inc[5:2];
                        end
                    end
                    else if (msg.end_of_message)
                    begin
                        state_next   = S_PAD;
                        pad2_next    = 1'b0;
                        pad_idx_next = pos[5:2];
                    end
                end
            end
            S_PAD:
            begin
                s_we    = 1'b1;
                s_waddr = pad_idx_reg;
                s_wdata = pad_word;
                if (pad_idx_reg == 4'd15)
                begin
                    job_next   = (!pad2_reg && pos >= 6'd56) ? JOB_SPILL : JOB_FINAL;
                    state_next = S_LOADV;
                    seq_next   = 4'd0;
                end
                else
                begin
                    pad_idx_next = pad_idx_reg + 4'd1;
                end
            end
            S_LOADV:
            begin
                c_raddr = seq_reg[2:0];
                if (seq_reg != 4'd0)
                begin
                    v_next[seqm1] = chv;
                end
                if (seq_reg == 4'd8)
                begin
                    state_next = S_RD1;
                    t_next     = 6'd0;
                end
                else
                begin
                    seq_next = seq_reg + 4'd1;
                end
            end
            S_RD1:
            begin
                s_ra_a     = t_reg[3:0];
                s_ra_b     = t_reg[3:0] + 4'd1;
                state_next = S_RD2;
            end
            S_RD2:
            begin
                s_ra_a     = t_reg[3:0] + 4'd9;
                s_ra_b     = t_reg[3:0] + 4'd14;
                x16_next   = rd_a;
                x15_next   = rd_b;
                wt_next    = rd_a;
                state_next = (t_reg[5:4] == 2'd0) ? S_RND : S_WN;
            end
            S_WN:
            begin
                s_we       = 1'b1;
                s_waddr    = t_reg[3:0];
                s_wdata    = w_new;
                wt_next    = w_new;
                state_next = S_RND;
            end
            S_RND:
            begin
                v_next = v_rnd;
                if (t_reg == 6'd63)
                begin
                    state_next = S_FINC;
                    seq_next   = 4'd0;
                end
                else
                begin
                    t_next     = t_reg + 6'd1;
                    state_next = S_RD1;
                end
            end
            S_FINC:
            begin
                c_raddr = seq_reg[2:0];
                if (seq_reg != 4'd0)
                begin
                    c_we            = 1'b1;
                    c_waddr         = seqm1;
                    c_wdata         = chv + v_reg[seqm1];
                    vld_next[seqm1] = 1'b1;
                end
                if (seq_reg == 4'd8)
                begin
                    unique case (job_reg)
                        JOB_DATA:
                        begin
                            if (end_pend_reg)
                            begin
                                state_next   = S_PAD;
                                pad2_next    = 1'b0;
                                pad_idx_next = pos[5:2];
                            end
                            else
                            begin
                                state_next = S_IDLE;
                            end
                        end
                        JOB_SPILL:
                        begin
                            state_next   = S_PAD;
                            pad2_next    = 1'b1;
                            pad_idx_next = '0;
                        end
                        default:
                        begin
                            state_next = S_OUT_RD;
                            oj_next    = 3'd0;
                        end
                    endcase
                end
                else
                begin
                    seq_next = seq_reg + 4'd1;
                end
            end
            S_OUT_RD:
            begin
                c_raddr    = oj_reg;
                state_next = S_OUT_LD;
            end
            S_OUT_LD:
            begin
                c_raddr = oj_reg;
                if (!dig_valid_reg || !dig_stall)
                begin
                    dig_load = 1'b1;
                    if (oj_reg == 3'd7)
                    begin
                        vld_next   = 8'h00;
                        cnt_next   = 32'h0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        oj_next    = oj_reg + 3'd1;
                        state_next = S_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= 32'h0;
            end_pend_reg  <= 1'b0;
            pad2_reg      <= 1'b0;
            pad_idx_reg   <= '0;
            job_reg       <= JOB_DATA;
            seq_reg       <= 4'd0;
            t_reg         <= 6'd0;
            vld_reg       <= 8'h00;
            oj_reg        <= 3'd0;
            dig_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            end_pend_reg <= end_pend_next;
            pad2_reg     <= pad2_next;
            pad_idx_reg  <= pad_idx_next;
            job_reg      <= job_next;
            seq_reg      <= seq_next;
            t_reg        <= t_next;
            vld_reg      <= vld_next;
            oj_reg       <= oj_next;
            if (dig_load)
            begin
                dig_valid_reg <= 1'b1;
            end
            else if (!dig_stall)
            begin
                dig_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x16_reg <= x16_next;
        x15_reg <= x15_next;
        wt_reg  <= wt_next;
        v_reg   <= v_next;
        if (dig_load)
        begin
            dig_reg.digest_word <= chv;
            dig_reg.word_number <= oj_reg;
            dig_reg.last_word   <= (oj_reg == 3'd7);
        end
    end

    `SMH_ASSERT_NEXT(a_last_round, state_reg == S_RND && t_reg == 6'd63, state_reg == S_FINC, "round 63 not followed by chain update")
    `SMH_ASSERT_NEXT(a_full_block, accept && msg.byte_present && pos == 6'd63, state_reg == S_LOADV && seq_reg == 4'd0, "full block did not start compression")
    `SMH_ASSERT_NEXT(a_restart, dig_load && oj_reg == 3'd7, vld_reg == 8'h00 && cnt_reg == 32'h0 && dig_valid_reg && dig_reg.last_word, "hash did not restart after last digest beat")
    `SMH_ASSERT_IMPL(a_readout_busy, dig_valid_reg && !dig_reg.last_word, state_reg == S_OUT_RD || state_reg == S_OUT_LD, "digest readout left before last word")

endmodule

// File: tb/tb.sv
// self-checking testbench of the sha-256 message hash block
`timescale 1ns / 1ps

module tb;

    logic                clk;
    logic                rst_n;
    logic                msg_valid;
    logic                msg_stall;
    smh_pkg::msg_beat_t  msg;
    logic                dig_valid;
    logic                dig_stall;
    smh_pkg::dig_beat_t  dig;

    sha256_message_hash_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg_stall (msg_stall),
        .msg       (msg),
        .dig_valid (dig_valid),
        .dig_stall (dig_stall),
        .dig       (dig)
    );

    // hash state of the predictor
    logic [31:0] hash_chain [8];
    logic [31:0] sched [16];
    logic [31:0] msg_len;

    smh_pkg::msg_beat_t pending_beats [$];
    smh_pkg::dig_beat_t digest_queue [$];
    int        n_errors;
    int        n_digests;
    int        n_words;
    bit        stim_done;
    int        hold_off;
    bit        beat_active;

    localparam logic [31:0] IV [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
        32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    localparam logic [31:0] RK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // one 64-round compression of the current block into the chain
    task automatic compress();
        logic [31:0] v [8];
        logic [31:0] x, y, t1, t2;
        for (int j = 0; j < 8; j++)
            v[j] = hash_chain[j];
        for (int t = 0; t < 64; t++)
        begin
            if (t >= 16)
            begin
                x = sched[(t + 1) & 15];
                y = sched[(t + 14) & 15];
                sched[t & 15] = sched[t & 15] + sched[(t + 9) & 15]
                    + (ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3))
                    + (ror32(y, 17) ^ ror32(y, 19) ^ (y >> 10));
            end
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[t] + sched[t & 15];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++)
            hash_chain[j] = hash_chain[j] + v[j];
    endtask

    // absorb one accepted beat, queue the digest on an end mark
    task automatic hash_beat(input smh_pkg::msg_beat_t b);
        int pos, wi, sh;
        smh_pkg::dig_beat_t d;
        if (b.byte_present)
        begin
            pos = msg_len[5:0];
            wi = pos >> 2;
            sh = 24 - 8 * (pos & 3);
            if ((pos & 3) == 0)
                sched[wi] = {b.data_byte, 24'h0};
            else
                sched[wi] = sched[wi] | (32'(b.data_byte) << sh);
            msg_len = msg_len + 1;
            if (msg_len[5:0] == 0)
                compress();
        end
        if (b.end_of_message)
        begin
            pos = msg_len[5:0];
            wi = pos >> 2;
            sh = 24 - 8 * (pos & 3);
            if ((pos & 3) == 0)
                sched[wi] = 32'h8000_0000;
            else
                sched[wi] = (sched[wi] & ~((32'h1 << (sh + 8)) - 1)) | (32'h80 << sh);
            for (int j = wi + 1; j < 16; j++)
                sched[j] = 0;
            if (pos >= 56)
            begin
                compress();
                for (int j = 0; j < 16; j++)
                    sched[j] = 0;
            end
            sched[14] = 0;
            sched[15] = msg_len << 3;
            compress();
            for (int j = 0; j < 8; j++)
            begin
                d.digest_word = hash_chain[j];
                d.word_number = 3'(j);
                d.last_word = (j == 7);
                digest_queue.push_back(d);
                hash_chain[j] = IV[j];
            end
            msg_len = 0;
        end
    endtask

    function automatic smh_pkg::msg_beat_t make_beat(input bit present, input bit eom,
                                                     input logic [7:0] val);
        smh_pkg::msg_beat_t b;
        b.data_byte = val;
        b.byte_present = present;
        b.end_of_message = eom;
        return b;
    endfunction

    // queue a message of given length with random content and end style
    task automatic add_message(input int len);
        bit tail;
        tail = (len > 0) && $urandom_range(0, 1);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                pending_beats.push_back(make_beat(0, 0, 8'($urandom)));
            pending_beats.push_back(make_beat(1, tail && i == len - 1, 8'($urandom)));
        end
        if (!tail)
            pending_beats.push_back(make_beat(0, 1, 8'($urandom)));
    endtask

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    endfunction

    always #2 clk = ~clk;

    // stimulus: directed messages first, then random ones
    initial
    begin
        int lens [$];
        lens = '{0, 1, 3, 55, 56, 63, 64};
        for (int i = 0; i < 16; i++)
            sched[i] = 0;
        for (int j = 0; j < 8; j++)
            hash_chain[j] = IV[j];
        msg_len = 0;
        // an idle beat, extremes of the byte, then the padding boundaries
        pending_beats.push_back(make_beat(0, 0, 8'hff));
        pending_beats.push_back(make_beat(1, 0, 8'h00));
        pending_beats.push_back(make_beat(1, 0, 8'hff));
        pending_beats.push_back(make_beat(1, 1, 8'h80));
        pending_beats.push_back(make_beat(0, 1, 8'h00));
        foreach (lens[i])
            add_message(lens[i]);
        while (pending_beats.size() < 480)
            add_message(($urandom_range(0, 3) == 0) ? $urandom_range(50, 130)
                                                     : $urandom_range(0, 20));
    end

    initial
    begin
        clk = 0;
        rst_n = 0;
        msg_valid = 0;
        msg = '0;
        dig_stall = 0;
        n_errors = 0;
        n_digests = 0;
        n_words = 0;
        stim_done = 0;
        hold_off = 0;
        beat_active = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
    end

    // driver: offers beats at the falling edge with random gaps
    int drv_gap;
    initial drv_gap = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!msg_valid || !beat_active)
            begin
                if (drv_gap > 0)
                begin
                    drv_gap <= drv_gap - 1;
                    msg_valid <= 0;
                end
                else if (pending_beats.size() > 0)
                begin
                    msg <= pending_beats.pop_front();
                    msg_valid <= 1;
                    beat_active <= 1;
                    drv_gap <= gap_len();
                end
                else
                begin
                    msg_valid <= 0;
                    stim_done <= 1;
                end
            end
        end
    end

    // acceptance of a beat on the msg side
    always @(posedge clk)
    begin
        if (rst_n && msg_valid && !msg_stall && beat_active)
        begin
            hash_beat(msg);
            beat_active <= 0;
        end
    end

    // receiver stall: random gaps plus one long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (n_digests == 3 && hold_off == 0)
            begin
                hold_off <= 1;
                dig_stall <= 1;
            end
            else if (hold_off > 0 && hold_off < 2000)
            begin
                hold_off <= hold_off + 1;
                dig_stall <= 1;
            end
            else
                dig_stall <= ($urandom_range(0, 3) == 0) ? 1'b1 : 1'b0;
        end
    end

    // monitor: compare digest beats with the predicted words
    always @(posedge clk)
    begin
        smh_pkg::dig_beat_t exp_beat;
        if (rst_n && dig_valid && !dig_stall)
        begin
            n_words <= n_words + 1;
            if (dig.last_word)
                n_digests <= n_digests + 1;
            if (digest_queue.size() == 0)
            begin
                $display("%0t: unexpected digest beat %h", $time, dig);
                n_errors <= n_errors + 1;
            end
            else
            begin
                exp_beat = digest_queue.pop_front();
                if (dig.digest_word !== exp_beat.digest_word
                    || dig.word_number !== exp_beat.word_number
                    || dig.last_word !== exp_beat.last_word)
                begin
                    $display("%0t: digest mismatch expected %h actual %h",
                             $time, exp_beat, dig);
                    n_errors <= n_errors + 1;
                end
            end
        end
    end

    // end of run once every beat is in and every digest word is out
    initial
    begin
        wait (rst_n);
        wait (stim_done && !msg_valid && digest_queue.size() == 0);
        repeat (100) @(posedge clk);
        $display("covered %0d digests (%0d words) over random message lengths,",
                 n_digests, n_words);
        $display("padding boundaries, idle beats and a long output hold-off");
        if (n_errors == 0 && digest_queue.size() == 0)
            $display("sha256_message_hash_top regression: pass");
        else
            $display("sha256_message_hash_top regression: fail");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("sha256_message_hash_top regression: fail");
        $finish;
    end
endmodule
